[sv/gap_buffer_text_store_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the gap buffer text store
// Clocked, reset-qualified property forms shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef GAP_BUFFER_TEXT_STORE_ASSERT_SVH
`define GAP_BUFFER_TEXT_STORE_ASSERT_SVH

// Same-cycle implication.
`define GBTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gbts check failed");

// Next-cycle implication.
`define GBTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gbts sequencing check failed");

`endif

[sv/gbts_pkg.sv]
// ---------------------------------------------------------------------------
// Gap buffer text store package
// Request codes, status codes and beat payload types.
// ---------------------------------------------------------------------------
package gbts_pkg;

    localparam int REQ_W  = 3;
    localparam int POS_W  = 9;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 2;

    localparam logic [REQ_W-1:0] REQ_MOVE   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_CHOP   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_AT_START = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [POS_W-1:0]  position;
        logic [BYTE_W-1:0] data_byte;
    } req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_byte;
        logic [POS_W-1:0]  text_length;
        logic [POS_W-1:0]  cursor_pos;
        logic [STAT_W-1:0] status;
    } rsp_t;

endpackage

[sv/gbts_if.sv]
// ---------------------------------------------------------------------------
// Gap buffer text store channels
// Request and response valid/ready channels with flat payload fields.
// ---------------------------------------------------------------------------
interface gbts_req_if;
    logic                        valid;
    logic                        ready;
    logic [gbts_pkg::REQ_W-1:0]  req_type;
    logic [gbts_pkg::POS_W-1:0]  position;
    logic [gbts_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output req_type, output position, output data_byte,
                    input ready);
    modport sink   (input valid, input req_type, input position, input data_byte,
                    output ready);
endinterface

interface gbts_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [gbts_pkg::BYTE_W-1:0] read_byte;
    logic [gbts_pkg::POS_W-1:0]  text_length;
    logic [gbts_pkg::POS_W-1:0]  cursor_pos;
    logic [gbts_pkg::STAT_W-1:0] status;

    modport source (output valid, output read_byte, output text_length,
                    output cursor_pos, output status, input ready);
    modport sink   (input valid, input read_byte, input text_length,
                    input cursor_pos, input status, output ready);
endinterface

[sv/gap_buffer_text_store.sv]
// ---------------------------------------------------------------------------
// Gap buffer text store
// Byte store with a movable gap at the cursor, driven by a small sequencer
// that shares one address adder and one memory read/write port pair.
// ---------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------
//  req     | in  | req_type, position, data_byte
//  rsp     | out | read_byte, text_length, cursor_pos, status
//
//  Insert, delete, chop and unused codes go from idle through exec to fin.
//  Read adds a wait state for the one registered memory read.
//  Move copies the bytes across the gap one at a time: each byte is
//  one memory read then one memory write through the shared address adder.
//  Reset zeroes the cursor and opens the gap over the whole store; the store
//  contents stay undefined.
//  req.ready is high only in idle; a held result stalls the next completion.
// ---------------------------------------------------------------------------
module gap_buffer_text_store #(
    parameter int BUF_SIZE = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    gbts_req_if.sink   req,
    gbts_rsp_if.source rsp
);

    localparam int CW = $clog2(BUF_SIZE + 1);
    localparam int PW = (CW > gbts_pkg::POS_W) ? CW : gbts_pkg::POS_W;
    localparam int AW = (BUF_SIZE > 1) ? $clog2(BUF_SIZE) : 1;
    localparam logic [PW-1:0] BUF_PW = PW'(BUF_SIZE);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_COPY_RD = 3'd2;
    localparam logic [2:0] S_COPY_WR = 3'd3;
    localparam logic [2:0] S_RD_WAIT = 3'd4;
    localparam logic [2:0] S_FIN     = 3'd5;

    logic [2:0]       state_reg, state_next;
    gbts_pkg::req_t   req_reg;
    logic [PW-1:0]    cursor_reg, cursor_next;
    logic [PW-1:0]    gap_reg, gap_next;
    logic [PW-1:0]    target_reg, target_next;
    logic [gbts_pkg::BYTE_W-1:0] rdbyte_reg, rdbyte_next;
    logic [gbts_pkg::STAT_W-1:0] stat_reg, stat_next;
    gbts_pkg::rsp_t   out_reg;
    logic             out_valid_reg;

    logic [gbts_pkg::BYTE_W-1:0] mem [BUF_SIZE];
    logic [gbts_pkg::BYTE_W-1:0] mem_rdata_reg;
    logic             mem_rd_en, mem_wr_en;
    logic [AW-1:0]    mem_rd_addr, mem_wr_addr;
    logic [gbts_pkg::BYTE_W-1:0] mem_wr_data;

    logic [PW-1:0]    len;
    logic [PW-1:0]    pos_ext;
    logic [PW-1:0]    cursor_m1;
    logic [PW-1:0]    add_a, add_sum;
    logic             move_down;
    logic             out_free;
    logic             in_copy;

    assign len       = BUF_PW - gap_reg;
    assign pos_ext   = PW'(req_reg.position);
    assign cursor_m1 = cursor_reg - PW'(1);
    assign move_down = cursor_reg > target_reg;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign in_copy   = (state_reg == S_COPY_RD) || (state_reg == S_COPY_WR);

    // Shared address adder: physical index of a logical position past the gap.
    always_comb
    begin
        if (state_reg == S_EXEC)
        begin
            add_a = pos_ext;
        end
        else if (move_down)
        begin
            add_a = cursor_m1;
        end
        else
        begin
            add_a = cursor_reg;
        end
    end
    assign add_sum = add_a + gap_reg;

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        gap_next    = gap_reg;
        target_next = target_reg;
        rdbyte_next = rdbyte_reg;
        stat_next   = stat_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = add_sum[AW-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = cursor_reg[AW-1:0];
        mem_wr_data = req_reg.data_byte;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                rdbyte_next = '0;
                stat_next   = gbts_pkg::ST_OK;
                state_next  = S_FIN;
                case (req_reg.req_type)
                    gbts_pkg::REQ_MOVE:
                    begin
                        // Clamp to the text length.
                        target_next = (pos_ext > len) ? len : pos_ext;
                        if (cursor_reg != target_next)
                        begin
                            state_next = S_COPY_RD;
                        end
                    end
                    gbts_pkg::REQ_INSERT:
                    begin
                        if (gap_reg == '0)
                        begin
                            stat_next = gbts_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_wr_en   = 1'b1;
                            cursor_next = cursor_reg + PW'(1);
                            gap_next    = gap_reg - PW'(1);
                        end
                    end
                    gbts_pkg::REQ_DELETE:
                    begin
                        if (cursor_reg == '0)
                        begin
                            stat_next = gbts_pkg::ST_AT_START;
                        end
                        else
                        begin
                            cursor_next = cursor_m1;
                            gap_next    = gap_reg + PW'(1);
                        end
                    end
                    gbts_pkg::REQ_CHOP:
                    begin
                        gap_next = BUF_PW - cursor_reg;
                    end
                    gbts_pkg::REQ_READ:
                    begin
                        if (pos_ext >= len)
                        begin
                            stat_next = gbts_pkg::ST_RANGE;
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = (pos_ext < cursor_reg) ? pos_ext[AW-1:0]
                                                                 : add_sum[AW-1:0];
                            state_next  = S_RD_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_COPY_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = move_down ? cursor_m1[AW-1:0] : add_sum[AW-1:0];
                state_next  = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = mem_rdata_reg;
                if (move_down)
                begin
                    mem_wr_addr = add_sum[AW-1:0];
                    cursor_next = cursor_m1;
                end
                else
                begin
                    mem_wr_addr = cursor_reg[AW-1:0];
                    cursor_next = cursor_reg + PW'(1);
                end
                state_next = (cursor_next == target_reg) ? S_FIN : S_COPY_RD;
            end
            S_RD_WAIT:
            begin
                rdbyte_next = mem_rdata_reg;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                // Hold until the output register is free.
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= '0;
            gap_reg       <= BUF_PW;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            gap_reg    <= gap_next;
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        target_reg <= target_next;
        rdbyte_reg <= rdbyte_next;
        stat_reg   <= stat_next;
        if (req.valid && req.ready)
        begin
            req_reg.req_type  <= req.req_type;
            req_reg.position  <= req.position;
            req_reg.data_byte <= req.data_byte;
        end
        if (state_reg == S_FIN && out_free)
        begin
            out_reg.read_byte   <= rdbyte_reg;
            out_reg.text_length <= len[gbts_pkg::POS_W-1:0];
            out_reg.cursor_pos  <= cursor_reg[gbts_pkg::POS_W-1:0];
            out_reg.status      <= stat_reg;
        end
    end

    // Store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            mem_rdata_reg <= mem[mem_rd_addr];
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_byte   = out_reg.read_byte;
    assign rsp.text_length = out_reg.text_length;
    assign rsp.cursor_pos  = out_reg.cursor_pos;
    assign rsp.status      = out_reg.status;

`include "gap_buffer_text_store_assert.svh"

    `GBTS_ASSERT_NOW(a_layout_fits, clk, rst_n, 1'b1, (cursor_reg + gap_reg) <= BUF_PW)
    `GBTS_ASSERT_NEXT(a_accept_exec, clk, rst_n, req.valid && req.ready, state_reg == S_EXEC)
    `GBTS_ASSERT_NEXT(a_copy_steps, clk, rst_n, state_reg == S_COPY_WR, cursor_reg != $past(cursor_reg))
    `GBTS_ASSERT_NOW(a_copy_gap_held, clk, rst_n, in_copy, gap_next == gap_reg)

endmodule

[tb/tb_gap_buffer_text_store.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Gap buffer text store testbench
// Directed edge cases, then random editing sequences (typing bursts, edits,
// reads, chops, far moves, fills to capacity and noise). A clocked driver
// and a clocked monitor throttle both channels at random. Every accepted
// request is run through a logical text model. Each response beat is checked
// field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_gap_buffer_text_store;
    import gbts_pkg::*;

    localparam int BUF_SIZE       = 256;
    localparam int ITEM_TARGET    = 450;
    localparam int QUIET_TAIL     = 60;
    localparam int DRAIN_CYCLES   = 600;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_C = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    always #6 clk = ~clk;

    gbts_req_if req_ch ();
    gbts_rsp_if rsp_ch ();

    gap_buffer_text_store #(.BUF_SIZE(BUF_SIZE)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    req_t pending_reqs[$];
    rsp_t predicted_rsps[$];

    // logical text as seen through the gap
    logic [BYTE_W-1:0] text_bytes[BUF_SIZE];
    int text_len;
    int text_cur;

    // length and cursor as the request plan will leave them
    int plan_len;
    int plan_cur;

    int err_count;
    int accepted_cnt;
    int beat_cnt;
    int quiet_from;
    int src_idle;
    int snk_idle;
    int stall_cycles;
    logic fill_done;
    rsp_t want;

    function automatic rsp_t predict_edit(input req_t r);
        rsp_t o;
        int i;
        int target;
        o = '0;
        o.status = ST_OK;
        case (r.req_type)
            REQ_MOVE:
            begin
                target = r.position;
                text_cur = (target > text_len) ? text_len : target;
            end
            REQ_INSERT:
            begin
                if (text_len == BUF_SIZE)
                    o.status = ST_FULL;
                else
                begin
                    for (i = text_len; i > text_cur; i--)
                        text_bytes[i] = text_bytes[i-1];
                    text_bytes[text_cur] = r.data_byte;
                    text_cur++;
                    text_len++;
                end
            end
            REQ_DELETE:
            begin
                if (text_cur == 0)
                    o.status = ST_AT_START;
                else
                begin
                    for (i = text_cur - 1; i < text_len - 1; i++)
                        text_bytes[i] = text_bytes[i+1];
                    text_cur--;
                    text_len--;
                end
            end
            REQ_CHOP:
                text_len = text_cur;
            REQ_READ:
            begin
                if (int'(r.position) >= text_len)
                    o.status = ST_RANGE;
                else
                    o.read_byte = text_bytes[r.position];
            end
            default:
                ;
        endcase
        o.text_length = text_len[POS_W-1:0];
        o.cursor_pos  = text_cur[POS_W-1:0];
        return o;
    endfunction

    task automatic add_req(input logic [REQ_W-1:0] kind, input int pos, input int dat);
        req_t r;
        r.req_type  = kind;
        r.position  = pos[POS_W-1:0];
        r.data_byte = dat[BYTE_W-1:0];
        pending_reqs.push_back(r);
        case (kind)
            REQ_MOVE:
                plan_cur = (int'(r.position) > plan_len) ? plan_len : int'(r.position);
            REQ_INSERT:
            begin
                if (plan_len < BUF_SIZE)
                begin
                    plan_len++;
                    plan_cur++;
                end
            end
            REQ_DELETE:
            begin
                if (plan_cur > 0)
                begin
                    plan_cur--;
                    plan_len--;
                end
            end
            REQ_CHOP:
                plan_len = plan_cur;
            default:
                ;
        endcase
    endtask

    task automatic report_mismatch(input string field, input int got, input int exp_val);
        $display("ERROR beat %0d: %s = %0d, predicted %0d", beat_cnt, field, got, exp_val);
        err_count++;
    endtask

    // a read position: mostly inside the text, sometimes past it
    function automatic int read_pos();
        if (plan_len == 0 || $urandom_range(0, 4) == 0)
            return $urandom_range(plan_len, 2**POS_W - 1);
        return $urandom_range(0, plan_len - 1);
    endfunction

    task automatic fill_to_capacity();
        int n;
        while (plan_len < BUF_SIZE)
            add_req(REQ_INSERT, $urandom_range(0, 511), $urandom_range(0, 255));
        n = $urandom_range(1, 3);
        repeat (n) add_req(REQ_INSERT, 0, $urandom_range(0, 255));
        add_req(REQ_READ, BUF_SIZE - 1, 0);
        add_req(REQ_READ, BUF_SIZE, 0);
        add_req(REQ_MOVE, $urandom_range(0, 255), 0);
        add_req(REQ_INSERT, 0, $urandom_range(0, 255));
        add_req(REQ_DELETE, 0, 0);
        add_req(REQ_INSERT, 0, $urandom_range(0, 255));
        add_req(REQ_MOVE, 0, 0);
        add_req(REQ_MOVE, 2**POS_W - 1, 0);
        fill_done = 1'b1;
    endtask

    task automatic build_stimulus();
        int choice;
        int n;
        // directed: empty store, extreme bytes, clamping, chop and spare codes
        add_req(REQ_READ, 0, 0);
        add_req(REQ_DELETE, 0, 8'hFF);
        add_req(REQ_MOVE, 300, 0);
        add_req(REQ_CHOP, 0, 0);
        add_req(REQ_INSERT, 0, 8'h00);
        add_req(REQ_INSERT, 511, 8'hFF);
        add_req(REQ_INSERT, 0, 8'hA5);
        add_req(REQ_INSERT, 0, 8'h5A);
        add_req(REQ_READ, 0, 0);
        add_req(REQ_READ, 3, 0);
        add_req(REQ_READ, 4, 0);
        add_req(REQ_READ, 511, 0);
        add_req(REQ_MOVE, 0, 0);
        add_req(REQ_DELETE, 0, 0);
        add_req(REQ_MOVE, 2, 0);
        add_req(REQ_DELETE, 0, 0);
        add_req(REQ_INSERT, 0, 8'h3C);
        add_req(REQ_MOVE, 511, 0);
        add_req(REQ_MOVE, 1, 0);
        add_req(REQ_CHOP, 0, 0);
        add_req(REQ_READ, 1, 0);
        add_req(REQ_READ, 256, 0);
        add_req(REQ_SPARE_A, 257, 8'h81);
        add_req(REQ_SPARE_B, 0, 0);
        add_req(REQ_SPARE_C, 511, 8'hFF);

        while (pending_reqs.size() < ITEM_TARGET)
        begin
            if (!fill_done && pending_reqs.size() > 120)
                fill_to_capacity();
            choice = $urandom_range(0, 99);
            if (choice < 35)
            begin
                // typing burst, sometimes somewhere in the middle
                if ($urandom_range(0, 2) == 0)
                    add_req(REQ_MOVE, $urandom_range(0, plan_len), 0);
                n = $urandom_range(1, 12);
                repeat (n) add_req(REQ_INSERT, $urandom_range(0, 511), $urandom_range(0, 255));
            end
            else if (choice < 50)
            begin
                add_req(REQ_MOVE, $urandom_range(0, plan_len), $urandom_range(0, 255));
                n = $urandom_range(1, 4);
                repeat (n) add_req(REQ_DELETE, $urandom_range(0, 511), 0);
                n = $urandom_range(0, 3);
                repeat (n) add_req(REQ_INSERT, 0, $urandom_range(0, 255));
            end
            else if (choice < 65)
            begin
                n = $urandom_range(1, 6);
                repeat (n) add_req(REQ_READ, read_pos(), $urandom_range(0, 255));
            end
            else if (choice < 72)
            begin
                add_req(REQ_MOVE, $urandom_range(0, plan_len), 0);
                add_req(REQ_CHOP, $urandom_range(0, 511), $urandom_range(0, 255));
                if ($urandom_range(0, 1) == 0)
                    add_req(REQ_READ, read_pos(), 0);
            end
            else if (choice < 85)
            begin
                if ($urandom_range(0, 1) == 0)
                    add_req(REQ_MOVE, $urandom_range(0, 511), $urandom_range(0, 255));
                else
                    add_req(REQ_MOVE, $urandom_range(0, plan_len), 0);
            end
            else if (choice < 92)
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                    add_req(3'($urandom_range(0, 7)), $urandom_range(0, 511),
                            $urandom_range(0, 255));
            end
            else if (plan_len > 180)
                fill_to_capacity();
            else
            begin
                n = $urandom_range(10, 24);
                repeat (n) add_req(REQ_INSERT, 0, $urandom_range(0, 255));
            end
        end
    endtask

    function automatic logic idling_on();
        return (accepted_cnt < quiet_from) && ((accepted_cnt % 80) < 55);
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.req_type  <= REQ_MOVE;
            req_ch.position  <= '0;
            req_ch.data_byte <= '0;
            src_idle         <= 0;
            accepted_cnt     <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predicted_rsps.push_back(predict_edit({req_ch.req_type, req_ch.position,
                                                       req_ch.data_byte}));
                accepted_cnt <= accepted_cnt + 1;
            end
            // hold the beat until it is taken
            if (!req_ch.valid || req_ch.ready)
            begin
                if (src_idle != 0)
                begin
                    req_ch.valid <= 1'b0;
                    src_idle     <= src_idle - 1;
                end
                else if (pending_reqs.size() != 0)
                begin
                    req_t nxt;
                    nxt = pending_reqs.pop_front();
                    req_ch.valid     <= 1'b1;
                    req_ch.req_type  <= nxt.req_type;
                    req_ch.position  <= nxt.position;
                    req_ch.data_byte <= nxt.data_byte;
                    if (idling_on() && $urandom_range(0, 7) == 0)
                        src_idle <= $urandom_range(1, 5);
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            snk_idle     <= 0;
            beat_cnt     <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (predicted_rsps.size() == 0)
                    report_mismatch("unexpected beat, cursor_pos", rsp_ch.cursor_pos, -1);
                else
                begin
                    want = predicted_rsps.pop_front();
                    if (rsp_ch.read_byte !== want.read_byte)
                        report_mismatch("read_byte", rsp_ch.read_byte, want.read_byte);
                    if (rsp_ch.text_length !== want.text_length)
                        report_mismatch("text_length", rsp_ch.text_length, want.text_length);
                    if (rsp_ch.cursor_pos !== want.cursor_pos)
                        report_mismatch("cursor_pos", rsp_ch.cursor_pos, want.cursor_pos);
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", rsp_ch.status, want.status);
                end
                beat_cnt <= beat_cnt + 1;
            end
            if (snk_idle != 0)
            begin
                rsp_ch.ready <= 1'b0;
                snk_idle     <= snk_idle - 1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (idling_on() && $urandom_range(0, 7) == 0)
                    snk_idle <= $urandom_range(1, 5);
            end
        end
    end

    // advance on any beat; a long move is the slowest legal stretch
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no beat accepted for %0d cycles", stall_cycles);
            $display("Regression FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        rst_n            = 1'b0;
        err_count        = 0;
        text_len         = 0;
        text_cur         = 0;
        plan_len         = 0;
        plan_cur         = 0;
        fill_done        = 1'b0;
        foreach (text_bytes[i])
            text_bytes[i] = '0;

        build_stimulus();
        quiet_from = pending_reqs.size() - QUIET_TAIL;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || req_ch.valid || predicted_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (predicted_rsps.size() != 0)
            report_mismatch("responses missing", 0, predicted_rsps.size());
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
